FILE: design/lsec_pkg.sv
// lsec_pkg: shared types, constants and helpers for the level-set edge crossing block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lsec_pkg;

	localparam int MAX_SIDE    = 1024;
	localparam int SIDE_BITS   = $clog2(MAX_SIDE);
	localparam int COUNT_BITS  = SIDE_BITS + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int CELL_BITS   = 20;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SIDE_BITS-1:0]          side_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [CELL_BITS-1:0]          cell_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CONTOUR_LEVEL = 2'd0,
		REG_OUTER_COUNT   = 2'd1,
		REG_INNER_COUNT   = 2'd2
	} cfg_reg_t;

	// one accepted sample on its way to the segment stage
	typedef struct packed {
		logic  cur_low;
		logic  prior_low;
		logic  outer_used;
		logic  inner_used;
		cell_t out_hi;
		cell_t out_lo;
		cell_t in_hi;
		cell_t in_lo;
	} item_t;

	typedef struct packed {
		logic s1_valid;
		logic phase;
	} seg_status_t;

	// counts below 2 become 2, above MAX_SIDE become MAX_SIDE
	function automatic count_t clamp_count(input count_t c);
		count_t r;
		r = c;
		if (c < count_t'(2)) begin
			r = count_t'(2);
		end else if (c > count_t'(MAX_SIDE)) begin
			r = count_t'(MAX_SIDE);
		end
		return r;
	endfunction

endpackage

FILE: design/lsec_row_mem.sv
// lsec_row_mem: line buffer holding the previous row of samples
// single port, read-first, registered read data; uses lsec_pkg
`timescale 1ns / 1ps

module lsec_row_mem
	import lsec_pkg::*;
(
	input  logic    clk,
	input  logic    en,
	input  side_t   addr,
	input  sample_t wdata,
	output sample_t rdata
);

	sample_t mem [MAX_SIDE];
	sample_t rdata_q;

	// old contents come out while the new sample goes in at the same entry
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q    <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/lsec_front.sv
// lsec_front: grid position tracking, previous-sample register and cell index math
// feeds the segment stage and the line buffer; uses lsec_pkg
`timescale 1ns / 1ps

module lsec_front
	import lsec_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  logic    restart,
	input  sample_t sample,
	input  sample_t level,
	input  side_t   stride,
	input  side_t   outer_last,
	output item_t   item,
	output side_t   mem_addr
);

	side_t   outer_q;
	side_t   inner_q;
	cell_t   base_q;
	sample_t prior_q;

	cell_t   inner_ext;
	cell_t   stride_ext;
	cell_t   side_ext;
	logic    row_end;

	assign inner_ext  = cell_t'(inner_q);
	assign stride_ext = cell_t'(stride);
	assign side_ext   = stride_ext + cell_t'(1);
	assign row_end    = (inner_q == stride);

	always_comb begin
		item.cur_low    = (sample <= level);
		item.prior_low  = (prior_q <= level);
		item.outer_used = (outer_q != '0) && (inner_q != '0) && (inner_q < stride);
		item.inner_used = (inner_q != '0) && (outer_q != '0) && (outer_q < outer_last);
		item.out_hi     = base_q - stride_ext + inner_ext;
		item.out_lo     = base_q - side_ext + inner_ext;
		item.in_hi      = base_q + inner_ext - cell_t'(1);
		item.in_lo      = base_q + inner_ext - side_ext;
	end

	assign mem_addr = inner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			inner_q <= '0;
			base_q  <= '0;
			prior_q <= '0;
		end else if (restart) begin
			outer_q <= '0;
			inner_q <= '0;
			base_q  <= '0;
			prior_q <= '0;
		end else if (accept) begin
			prior_q <= sample;
			if (row_end) begin
				inner_q <= '0;
				if (outer_q == outer_last) begin
					outer_q <= '0;
					base_q  <= '0;
				end else begin
					outer_q <= outer_q + side_t'(1);
					base_q  <= base_q + stride_ext;
				end
			end else begin
				inner_q <= inner_q + side_t'(1);
			end
		end
	end

endmodule

FILE: design/lsec_seg_out.sv
// lsec_seg_out: segment stage and output register, up to two segments per sample
// takes items from lsec_front and old row data from lsec_row_mem; uses lsec_pkg
`timescale 1ns / 1ps

module lsec_seg_out
	import lsec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       item,
	input  sample_t     row_old,
	input  sample_t     level,
	output logic        out_valid,
	input  logic        out_ready,
	output cell_t       out_from,
	output cell_t       out_to,
	output logic        out_inner,
	output logic        out_last,
	output seg_status_t status
);

	item_t item_s1;
	logic  valid_s1;
	logic  phase_q;

	logic  out_valid_q;
	cell_t from_q;
	cell_t to_q;
	logic  inner_q;
	logic  last_q;

	logic  old_low;
	logic  outer_hit;
	logic  inner_hit;
	logic  outer_pend;
	logic  any_pend;
	logic  two_left;
	logic  out_free;
	logic  load_out;
	logic  done_s1;
	logic  take;

	always_comb begin
		old_low    = (row_old <= level);
		outer_hit  = item_s1.outer_used && (old_low != item_s1.cur_low);
		inner_hit  = item_s1.inner_used && (item_s1.prior_low != item_s1.cur_low);
		outer_pend = outer_hit && !phase_q;
		any_pend   = outer_pend || inner_hit;
		two_left   = outer_pend && inner_hit;
		out_free   = !out_valid_q || out_ready;
		load_out   = valid_s1 && any_pend && out_free;
		done_s1    = valid_s1 && (!any_pend || (out_free && !two_left));
		in_ready   = !valid_s1 || done_s1;
		take       = in_valid && in_ready;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			// phase set means the outer-edge beat has gone and the inner one remains
			if (take || done_s1) begin
				phase_q <= 1'b0;
			end else if (load_out && two_left) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (outer_pend) begin
				from_q  <= old_low ? item_s1.out_lo : item_s1.out_hi;
				to_q    <= old_low ? item_s1.out_hi : item_s1.out_lo;
				inner_q <= 1'b0;
				last_q  <= !inner_hit;
			end else begin
				from_q  <= item_s1.prior_low ? item_s1.in_lo : item_s1.in_hi;
				to_q    <= item_s1.prior_low ? item_s1.in_hi : item_s1.in_lo;
				inner_q <= 1'b1;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_from  = from_q;
	assign out_to    = to_q;
	assign out_inner = inner_q;
	assign out_last  = last_q;

	assign status.s1_valid = valid_s1;
	assign status.phase    = phase_q;

endmodule

FILE: design/levelset_edge_crossing_segments_top.sv
// levelset_edge_crossing_segments_top: edge crossing segment generator, top level
// instantiates lsec_front, lsec_row_mem and lsec_seg_out; uses lsec_pkg
`timescale 1ns / 1ps

// Grid samples enter on the s_ channel one beat per node, inner coordinate fastest.
// Each beat yields zero, one or two segment beats on the m_ channel: the edge to the
// node one row back first, then the edge to the previous node of the same row.
// m_tlast marks the final segment of a sample, m_tuser is set for the inner edge.
// A sample with no crossing produces no beat.
// A sample is registered in the segment stage, each segment in the output register.
// Throughput: one sample per cycle while each yields at most one segment and the
// receiver is ready; a sample with two segments holds the input until its second
// segment is loaded into the single output register, which sends one segment per cycle.
// The line buffer is one read-first memory port: every sample reads the node above
// and writes itself at the same entry in the same cycle.
// When the receiver stalls, the held segment stays in the output register and the
// segment stage fills, then s_tready drops; nothing is lost.
// Reset: level 0, both counts 1024, position at node (0,0), no clearing pass.
// Writing either count restarts the frame at node (0,0). cfg_ready is always high; the
// user writes configuration only while the block is idle; nothing here enforces it.

module levelset_edge_crossing_segments_top
	import lsec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [15:0]              s_tdata,   // [15:0] sample_value
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [39:0]              m_tdata,   // [19:0] from_cell, [39:20] to_cell
	output logic                     m_tuser,   // [0] across_inner_edge
	output logic                     m_tlast,   // final_of_item
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	sample_t     level_q;
	side_t       stride_q;
	side_t       outer_last_q;
	count_t      clamped;
	logic        cfg_wr;
	logic        restart;
	logic        accept;
	item_t       item;
	side_t       mem_addr;
	sample_t     row_old;
	cell_t       out_from;
	cell_t       out_to;
	seg_status_t st;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign clamped   = clamp_count(count_t'(cfg_data[COUNT_BITS-1:0]));
	assign restart   = cfg_wr && ((cfg_index == REG_OUTER_COUNT) ||
	                              (cfg_index == REG_INNER_COUNT));
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			stride_q     <= side_t'(MAX_SIDE - 1);
			outer_last_q <= side_t'(MAX_SIDE - 1);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_CONTOUR_LEVEL: level_q      <= sample_t'(cfg_data[SAMPLE_BITS-1:0]);
				REG_OUTER_COUNT:   outer_last_q <= side_t'(clamped - count_t'(1));
				REG_INNER_COUNT:   stride_q     <= side_t'(clamped - count_t'(1));
				default: ;
			endcase
		end
	end

	lsec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.restart    (restart),
		.sample     (sample_t'(s_tdata)),
		.level      (level_q),
		.stride     (stride_q),
		.outer_last (outer_last_q),
		.item       (item),
		.mem_addr   (mem_addr)
	);

	lsec_row_mem u_row_mem (
		.clk   (clk),
		.en    (accept),
		.addr  (mem_addr),
		.wdata (sample_t'(s_tdata)),
		.rdata (row_old)
	);

	lsec_seg_out u_seg_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.row_old   (row_old),
		.level     (level_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_from  (out_from),
		.out_to    (out_to),
		.out_inner (m_tuser),
		.out_last  (m_tlast),
		.status    (st)
	);

	assign m_tdata = {out_to, out_from};

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!st.s1_valid |-> s_tready)
		else $error("segment stage empty but input not ready");

	a_phase_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		st.phase |-> st.s1_valid)
		else $error("second segment pending with no item in the segment stage");

	a_first_beat_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> st.phase)
		else $error("non-final segment shown without its inner segment pending");

	a_first_beat_outer: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tuser)
		else $error("non-final segment is not an outer edge");

endmodule

FILE: test/lsec_segment_checker.sv
`timescale 1ns / 1ps
// lsec_segment_checker: watches the sample, segment and config channels of the edge crossing
// block, predicts the segments each sample causes and compares them with the output beats
// depends on lsec_pkg for widths, register names and cell types

module lsec_segment_checker
	import lsec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [15:0]              s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [39:0]              m_tdata,
	input  logic                     m_tuser,
	input  logic                     m_tlast,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       segs_pending
);

	typedef struct {
		cell_t from_cell;
		cell_t to_cell;
		logic  inner_edge;
		logic  last_seg;
	} segment_t;

	segment_t segs_due[$];

	sample_t     level;
	count_t      outer_raw;
	count_t      inner_raw;
	sample_t     line_buf [MAX_SIDE];
	sample_t     left_val;
	int unsigned row_at;
	int unsigned col_at;
	cell_t       row_base;

	function automatic int unsigned fit_count(count_t raw);
		if (raw < 2) return 2;
		if (raw > MAX_SIDE) return MAX_SIDE;
		return 32'(raw);
	endfunction

	function automatic void restart_frame();
		left_val = '0;
		row_at = 0;
		col_at = 0;
		row_base = '0;
	endfunction

	function automatic void match_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_segment();
		segment_t want;
		if (segs_due.size() == 0) begin
			$display("%0t ns: segment expected none, got from %0d to %0d inner %0b last %0b",
				$time, m_tdata[CELL_BITS-1:0], m_tdata[2*CELL_BITS-1:CELL_BITS], m_tuser,
				m_tlast);
			mismatches++;
		end else begin
			want = segs_due.pop_front();
			match_field("from_cell", 32'(want.from_cell), 32'(m_tdata[CELL_BITS-1:0]));
			match_field("to_cell", 32'(want.to_cell),
				32'(m_tdata[2*CELL_BITS-1:CELL_BITS]));
			match_field("across_inner_edge", 32'(want.inner_edge), 32'(m_tuser));
			match_field("final_of_item", 32'(want.last_seg), 32'(m_tlast));
		end
	endtask

	task automatic apply_reg();
		case (cfg_index)
			REG_CONTOUR_LEVEL: level = sample_t'(cfg_data);
			REG_OUTER_COUNT: begin
				outer_raw = cfg_data[COUNT_BITS-1:0];
				restart_frame();
			end
			REG_INNER_COUNT: begin
				inner_raw = cfg_data[COUNT_BITS-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endtask

	// segments caused by one grid node, edge to the row above first
	task automatic predict_segments(sample_t cur);
		int unsigned rows, cols, stride, o, i;
		logic        cur_low, old_low;
		cell_t       c;
		segment_t    seg;
		segment_t    batch[$];
		rows = fit_count(outer_raw);
		cols = fit_count(inner_raw);
		stride = cols - 1;
		o = row_at;
		i = col_at;
		cur_low = cur <= level;
		if (i >= cols || o >= rows) begin
			restart_frame();
			o = 0;
			i = 0;
		end
		if (o >= 1 && i >= 1 && i <= cols - 2) begin
			old_low = line_buf[i] <= level;
			c = cell_t'(row_base - stride + i);
			if (old_low != cur_low) begin
				seg.from_cell = old_low ? cell_t'(c - 1) : c;
				seg.to_cell = old_low ? c : cell_t'(c - 1);
				seg.inner_edge = 1'b0;
				seg.last_seg = 1'b0;
				batch.push_back(seg);
			end
		end
		if (i >= 1 && o >= 1 && o <= rows - 2) begin
			old_low = left_val <= level;
			c = cell_t'(row_base + i - 1);
			if (old_low != cur_low) begin
				seg.from_cell = old_low ? cell_t'(c - stride) : c;
				seg.to_cell = old_low ? c : cell_t'(c - stride);
				seg.inner_edge = 1'b1;
				seg.last_seg = 1'b0;
				batch.push_back(seg);
			end
		end
		if (batch.size() != 0) begin
			seg = batch.pop_back();
			seg.last_seg = 1'b1;
			batch.push_back(seg);
		end
		foreach (batch[k]) segs_due.push_back(batch[k]);

		line_buf[i] = cur;
		left_val = cur;
		if (i + 1 >= cols) begin
			col_at = 0;
			if (o + 1 >= rows) begin
				row_at = 0;
				row_base = '0;
			end else begin
				row_at = o + 1;
				row_base = cell_t'(row_base + stride);
			end
		end else begin
			col_at = i + 1;
			row_at = o;
		end
	endtask

	// output beats are checked before this edge's sample adds its segments
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level = '0;
			outer_raw = count_t'(MAX_SIDE);
			inner_raw = count_t'(MAX_SIDE);
			restart_frame();
			segs_due.delete();
			mismatches = 0;
			segs_pending = 0;
		end else begin
			if (m_tvalid && m_tready) check_segment();
			if (cfg_valid && cfg_ready) apply_reg();
			if (s_tvalid && s_tready) predict_segments(sample_t'(s_tdata));
			segs_pending = segs_due.size();
		end
	end

endmodule

FILE: test/levelset_edge_crossing_segments_top_test.sv
`timescale 1ns / 1ps
// levelset_edge_crossing_segments_top_test: drives grid samples, register writes and output
// back-pressure into the edge crossing block and reports the verdict
// depends on lsec_pkg, levelset_edge_crossing_segments_top and lsec_segment_checker

module levelset_edge_crossing_segments_top_test;
	import lsec_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 12;
	localparam int ITEM_TARGET  = 2000;
	localparam int WIDE_AFTER   = 600;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_PAD     = 6;
	localparam int QUIET_LIMIT  = 4000;
	// unmapped register index, writes to it are dropped
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [15:0]              s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [39:0]              m_tdata;
	logic                     m_tuser;
	logic                     m_tlast;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int      mismatches;
	int      segs_pending;
	int      quiet_cycles;
	bit      src_calm;
	bit      sink_calm;
	bit      long_hold_req;
	sample_t cur_level;

	sample_t corner_grid [9] = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
		16'h0001, 16'h7fff, 16'hffff, 16'h8000};
	sample_t column_run [8] = '{16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'hffff,
		16'h0002, 16'h0005, 16'hfffb};

	levelset_edge_crossing_segments_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lsec_segment_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.segs_pending (segs_pending)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return sample_t'($urandom);
			1: return cur_level;
			2: return $urandom_range(0, 1) ? sample_t'(16'h7fff) : sample_t'(16'h8000);
			// near the level so that crossings are frequent
			default: return sample_t'(cur_level + $urandom_range(0, 6) - 3);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 1));
			1: return 16'd1024;
			2: return 16'($urandom_range(1025, 65535));
			default: return 16'($urandom_range(2, 12));
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CONTOUR_LEVEL) cur_level = sample_t'(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// valid stays high into the next beat when no gap is drawn
	task automatic send_sample(sample_t v);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// block idle: no segment due and the pipeline given time to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (segs_pending != 0) @(negedge clk);
		repeat (IDLE_PAD) @(negedge clk);
	endtask

	initial begin : sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				stall = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				stall = sink_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int n_items;
		int samples_sent;
		bit wide_done;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		long_hold_req = 1'b0;
		cur_level = '0;
		samples_sent = 0;
		wide_done = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 3x3 grid of extremes, level moved and a dropped write in mid-frame
		set_reg(REG_CONTOUR_LEVEL, 16'h0000);
		set_reg(REG_INNER_COUNT, 16'd3);
		set_reg(REG_OUTER_COUNT, 16'd3);
		for (int k = 0; k < 4; k++) send_sample(corner_grid[k]);
		settle();
		set_reg(REG_NONE, 16'd3);
		set_reg(REG_CONTOUR_LEVEL, 16'h8000);
		for (int k = 4; k < 9; k++) send_sample(corner_grid[k]);
		settle();

		// top level, counts that clamp up and mask down
		set_reg(REG_CONTOUR_LEVEL, 16'h7fff);
		set_reg(REG_INNER_COUNT, 16'h0000);
		set_reg(REG_OUTER_COUNT, 16'h0805);
		for (int k = 0; k < 4; k++) send_sample(corner_grid[k]);
		settle();

		// two columns, tallest grid: inner edges only
		set_reg(REG_CONTOUR_LEVEL, 16'h0000);
		set_reg(REG_INNER_COUNT, 16'h0001);
		set_reg(REG_OUTER_COUNT, 16'hffff);
		foreach (column_run[k]) send_sample(column_run[k]);
		settle();

		// output held off for a long stretch while samples keep coming
		set_reg(REG_INNER_COUNT, 16'd5);
		set_reg(REG_OUTER_COUNT, 16'd6);
		src_calm = 1'b1;
		sink_calm = 1'b1;
		long_hold_req = 1'b1;
		repeat (150) send_sample(pick_sample());
		samples_sent = 150;

		while (samples_sent < ITEM_TARGET) begin
			settle();
			if (!wide_done && samples_sent >= WIDE_AFTER) begin
				// widest row and part of the next, count masked down from the upper bits
				set_reg(REG_CONTOUR_LEVEL, 16'($urandom));
				set_reg(REG_INNER_COUNT, 16'hfc00);
				set_reg(REG_OUTER_COUNT, 16'd2);
				n_items = MAX_SIDE + MAX_SIDE / 4;
				src_calm = 1'b1;
				sink_calm = 1'b1;
				wide_done = 1'b1;
			end else begin
				if ($urandom_range(0, 1)) set_reg(REG_CONTOUR_LEVEL, pick_level());
				if ($urandom_range(0, 1)) set_reg(REG_INNER_COUNT, pick_count());
				if ($urandom_range(0, 1)) set_reg(REG_OUTER_COUNT, pick_count());
				if ($urandom_range(0, 7) == 0) set_reg(REG_NONE, 16'($urandom));
				n_items = $urandom_range(10, 120);
				src_calm = ($urandom_range(0, 3) == 0);
				sink_calm = ($urandom_range(0, 3) == 0);
			end
			repeat (n_items) send_sample(pick_sample());
			samples_sent += n_items;
		end
		settle();

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/lsec_pkg.sv
design/lsec_row_mem.sv
design/lsec_front.sv
design/lsec_seg_out.sv
design/levelset_edge_crossing_segments_top.sv
test/lsec_segment_checker.sv
test/levelset_edge_crossing_segments_top_test.sv
